[design/weighted_bi_prediction_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the weighted bi-prediction core
// Clocked, reset-qualified implication forms.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_BI_PREDICTION_CORE_MACROS_SVH
`define WEIGHTED_BI_PREDICTION_CORE_MACROS_SVH

// same-cycle implication
`define WBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wbp assertion failed");

// next-cycle implication
`define WBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wbp assertion failed");

`endif

[design/wbp_pkg.sv]
// ---------------------------------------------------------------------------
// wbp_pkg
// Types, constants and the divider step shared by the blend core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbp_pkg;

	localparam int LANES   = 4;
	localparam int PIX_W   = 8;
	localparam int CNT_W   = 3;
	localparam int W_W     = 8;
	localparam int DEN_W   = 9;
	localparam int PROD_W  = W_W + PIX_W + 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int DIV_STG = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_W0  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_W1  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEN = 2'd2;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0] past_pix_a;
		logic [PIX_W-1:0] past_pix_b;
		logic [PIX_W-1:0] past_pix_c;
		logic [PIX_W-1:0] past_pix_d;
		logic [PIX_W-1:0] future_pix_a;
		logic [PIX_W-1:0] future_pix_b;
		logic [PIX_W-1:0] future_pix_c;
		logic [PIX_W-1:0] future_pix_d;
		logic [CNT_W-1:0] lanes_valid;
		logic             block_end;
	} pair_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] blend_pix_a;
		logic [PIX_W-1:0] blend_pix_b;
		logic [PIX_W-1:0] blend_pix_c;
		logic [PIX_W-1:0] blend_pix_d;
		logic [CNT_W-1:0] lanes_out;
		logic             block_end_out;
	} blend_beat_t;

	typedef struct packed {
		logic signed [W_W-1:0] w0;
		logic signed [W_W-1:0] w1;
		logic [DEN_W-1:0]      den;
		logic [DEN_W-1:0]      half;
	} cfg_t;

	// stage enables, indices 1..DIV_STG+2; there is no index 0
	typedef struct packed {
		logic [DIV_STG+2:1] en;
	} stage_ctrl_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [PIX_W-1:0] quo;
		logic [PIX_W-1:0] low;
		logic             zero;
		logic             sat;
	} div_t;

	function automatic div_t div_step(input div_t cur, input logic [DEN_W-1:0] den);
		div_t           nxt;
		logic [DEN_W:0] r;
		nxt = cur;
		r   = {cur.rem, cur.low[PIX_W-1]};
		nxt.low = {cur.low[PIX_W-2:0], 1'b0};
		if (r >= {1'b0, den}) begin
			r = r - {1'b0, den};
			nxt.quo = {cur.quo[PIX_W-2:0], 1'b1};
		end else begin
			nxt.quo = {cur.quo[PIX_W-2:0], 1'b0};
		end
		nxt.rem = r[DEN_W-1:0];
		return nxt;
	endfunction

endpackage

[design/wbp_pair_if.sv]
// ---------------------------------------------------------------------------
// wbp_pair_if
// Valid/ready channel carrying one group of pixel pairs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wbp_pair_if import wbp_pkg::*; ();
	logic       valid;
	logic       ready;
	pair_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/wbp_blend_if.sv]
// ---------------------------------------------------------------------------
// wbp_blend_if
// Valid/ready channel carrying one group of blended pixels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wbp_blend_if import wbp_pkg::*; ();
	logic        valid;
	logic        ready;
	blend_beat_t data;

	modport source  (output valid, output data, input ready);
	modport sink    (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

[design/weighted_bi_prediction_core.sv]
// ---------------------------------------------------------------------------
// weighted_bi_prediction_core
// Four-lane weighted blend of list0/list1 prediction pixels with clamp.
// ---------------------------------------------------------------------------
//  channel  dir  beat
//  pairs    in   4 pixel pairs, lane count, last mark
//  blend    out  4 blended pixels, lane count, last mark
//  cfg      in   write enable, index, 9-bit data
//
//  One beat per cycle sustained while blend is not stalled; registers are
//  multiply, sum, four two-bit divide stages and the output register.
//  Reset clears weights to 1, denominator to 2, and all stage valids.
//  A stall on blend holds the output beat; bubbles in the pipe are squeezed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_bi_prediction_core import wbp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	wbp_pair_if.sink             pairs,
	wbp_blend_if.source          blend,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DEN_W-1:0]     cfg_data
);

	localparam int NST = DIV_STG + 2;

	logic signed [W_W-1:0] w0_q, w1_q;
	logic [DEN_W-1:0]      den_q;
	cfg_t                  cfg;
	stage_ctrl_t           ctrl;
	logic [NST:1]          vld_s;
	logic [CNT_W-1:0]      cnt_s [NST:1];
	logic                  end_s [NST:1];
	logic                  mrg_ready;
	logic [LANES-1:0][PIX_W-1:0] past, future, lane_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q  <= 8'sd1;
			w1_q  <= 8'sd1;
			den_q <= 9'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_W0:  w0_q  <= cfg_data[W_W-1:0];
				REG_W1:  w1_q  <= cfg_data[W_W-1:0];
				REG_DEN: den_q <= (cfg_data == '0) ? DEN_W'(1) : cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.w0   = w0_q;
	assign cfg.w1   = w1_q;
	assign cfg.den  = den_q;
	assign cfg.half = den_q >> 1;

	always_comb begin
		ctrl.en[NST] = !vld_s[NST] || mrg_ready;
		for (int k = NST - 1; k >= 1; k--) begin
			ctrl.en[k] = !vld_s[k] || ctrl.en[k+1];
		end
	end

	assign pairs.ready = ctrl.en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ctrl.en[1]) vld_s[1] <= pairs.valid;
			for (int k = 2; k <= NST; k++) begin
				if (ctrl.en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			cnt_s[1] <= pairs.data.lanes_valid;
			end_s[1] <= pairs.data.block_end;
		end
		for (int k = 2; k <= NST; k++) begin
			if (ctrl.en[k]) begin
				cnt_s[k] <= cnt_s[k-1];
				end_s[k] <= end_s[k-1];
			end
		end
	end

	assign past   = {pairs.data.past_pix_d, pairs.data.past_pix_c,
	                 pairs.data.past_pix_b, pairs.data.past_pix_a};
	assign future = {pairs.data.future_pix_d, pairs.data.future_pix_c,
	                 pairs.data.future_pix_b, pairs.data.future_pix_a};

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		wbp_lane u_lane (
			.clk    (clk),
			.ctrl   (ctrl),
			.cfg    (cfg),
			.past   (past[i]),
			.future (future[i]),
			.pix    (lane_pix[i])
		);
	end

	wbp_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[NST]),
		.in_ready (mrg_ready),
		.lane_pix (lane_pix),
		.lanes    (cnt_s[NST]),
		.last     (end_s[NST]),
		.res      (blend)
	);

endmodule

[design/wbp_lane.sv]
// ---------------------------------------------------------------------------
// wbp_lane
// One blend lane: weight multiply, rounding sum, two-bit-per-stage divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbp_lane import wbp_pkg::*; (
	input  logic             clk,
	input  stage_ctrl_t      ctrl,
	input  cfg_t             cfg,
	input  logic [PIX_W-1:0] past,
	input  logic [PIX_W-1:0] future,
	output logic [PIX_W-1:0] pix
);

	logic signed [PROD_W-1:0] p0_s1, p1_s1;
	logic signed [SUM_W-1:0]  sum;
	div_t dv_s2, dv_s3, dv_s4, dv_s5, dv_s6;

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			p0_s1 <= cfg.w0 * $signed({1'b0, past});
			p1_s1 <= cfg.w1 * $signed({1'b0, future});
		end
	end

	assign sum = SUM_W'(p0_s1) + SUM_W'(p1_s1) + $signed(SUM_W'({1'b0, cfg.half}));

	// negative sums clamp to zero; quotient of 256 or more saturates
	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			dv_s2.zero <= sum[SUM_W-1];
			dv_s2.sat  <= {1'b0, sum[15:8]} >= cfg.den;
			dv_s2.rem  <= {1'b0, sum[15:8]};
			dv_s2.low  <= sum[7:0];
			dv_s2.quo  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) dv_s3 <= div_step(div_step(dv_s2, cfg.den), cfg.den);
		if (ctrl.en[4]) dv_s4 <= div_step(div_step(dv_s3, cfg.den), cfg.den);
		if (ctrl.en[5]) dv_s5 <= div_step(div_step(dv_s4, cfg.den), cfg.den);
		if (ctrl.en[6]) dv_s6 <= div_step(div_step(dv_s5, cfg.den), cfg.den);
	end

	assign pix = dv_s6.zero ? '0 : (dv_s6.sat ? PIX_MAX : dv_s6.quo);

endmodule

[design/wbp_merge.sv]
// ---------------------------------------------------------------------------
// wbp_merge
// Gathers lane results, masks unused lanes, holds the output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbp_merge import wbp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [LANES-1:0][PIX_W-1:0] lane_pix,
	input  logic [CNT_W-1:0]            lanes,
	input  logic                        last,
	wbp_blend_if.source                 res
);

	logic        vld_q;
	blend_beat_t beat_q;
	logic [LANES-1:0][PIX_W-1:0] m;

	assign in_ready = !vld_q || res.ready;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			m[i] = (CNT_W'(i) < lanes) ? lane_pix[i] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q.blend_pix_a   <= m[0];
			beat_q.blend_pix_b   <= m[1];
			beat_q.blend_pix_c   <= m[2];
			beat_q.blend_pix_d   <= m[3];
			beat_q.lanes_out     <= lanes;
			beat_q.block_end_out <= last;
		end
	end

	assign res.valid = vld_q;
	assign res.data  = beat_q;

endmodule

[design/wbp_checker.sv]
// ---------------------------------------------------------------------------
// wbp_checker
// Port-level checks on the blend output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_bi_prediction_core_macros.svh"

module wbp_checker import wbp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input blend_beat_t res_data
);

	`WBP_ASSERT_NEXT(a_hold_valid, res_valid && !res_ready, res_valid)
	`WBP_ASSERT_NEXT(a_hold_data, res_valid && !res_ready, $stable(res_data))
	`WBP_ASSERT_NOW(a_no_lanes, res_valid && res_data.lanes_out == 3'd0,
		res_data.blend_pix_a == 8'd0 && res_data.blend_pix_d == 8'd0)
	`WBP_ASSERT_NOW(a_one_lane, res_valid && res_data.lanes_out == 3'd1,
		res_data.blend_pix_b == 8'd0 && res_data.blend_pix_c == 8'd0)

endmodule

bind weighted_bi_prediction_core wbp_checker u_wbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (blend.valid),
	.res_ready (blend.ready),
	.res_data  (blend.data)
);

[tb/weighted_bi_prediction_core_tb.sv]
// ---------------------------------------------------------------------------
// weighted_bi_prediction_core_tb
// Drives pixel-pair beats into the blend core under several weight and
// denominator settings, with random sender gaps and receiver stalls.
// Every output beat is checked lane by lane against a local blend model or a fixed expected beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_bi_prediction_core_tb;
	import wbp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int LAT_CYC   = 7;
	localparam int CYC_LIMIT = 400000;
	localparam int SEG_CNT   = 12;
	localparam int SEG_ITEMS = 88;

	typedef struct {
		int          w0;
		int          w1;
		int          den;
		pair_beat_t  beat;
		bit          has_exp;
		blend_beat_t exp;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DEN_W-1:0]     cfg_data;

	wbp_pair_if  pairs ();
	wbp_blend_if blend ();

	weighted_bi_prediction_core dut (
		.clk(clk), .arst_n(arst_n), .pairs(pairs), .blend(blend),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	logic signed [W_W-1:0] wt_past;
	logic signed [W_W-1:0] wt_future;
	logic [DEN_W-1:0]      blend_den;
	blend_beat_t           blend_exp_q[$];
	dir_row_t              dir_rows[$];
	int                    err_cnt;
	int                    cyc_cnt;
	int                    gap_pct;
	int                    stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt > CYC_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] blend_pixel(input logic [PIX_W-1:0] p,
			input logic [PIX_W-1:0] f);
		int d;
		int s;
		int q;
		d = (blend_den == 0) ? 1 : int'(blend_den);
		s = int'(wt_past) * int'(p) + int'(wt_future) * int'(f) + d / 2;
		q = s / d;
		if (q < 0) q = 0;
		if (q > int'(PIX_MAX)) q = int'(PIX_MAX);
		return q[PIX_W-1:0];
	endfunction

	function automatic blend_beat_t blend_predict(input pair_beat_t b);
		blend_beat_t r;
		int n;
		n = int'(b.lanes_valid);
		r.blend_pix_a = (n > 0) ? blend_pixel(b.past_pix_a, b.future_pix_a) : '0;
		r.blend_pix_b = (n > 1) ? blend_pixel(b.past_pix_b, b.future_pix_b) : '0;
		r.blend_pix_c = (n > 2) ? blend_pixel(b.past_pix_c, b.future_pix_c) : '0;
		r.blend_pix_d = (n > 3) ? blend_pixel(b.past_pix_d, b.future_pix_d) : '0;
		r.lanes_out = b.lanes_valid;
		r.block_end_out = b.block_end;
		return r;
	endfunction

	function automatic pair_beat_t flat_pairs(input int p, input int f, input int n,
			input bit last);
		pair_beat_t b;
		b.past_pix_a = PIX_W'(p); b.past_pix_b = PIX_W'(p);
		b.past_pix_c = PIX_W'(p); b.past_pix_d = PIX_W'(p);
		b.future_pix_a = PIX_W'(f); b.future_pix_b = PIX_W'(f);
		b.future_pix_c = PIX_W'(f); b.future_pix_d = PIX_W'(f);
		b.lanes_valid = CNT_W'(n);
		b.block_end = last;
		return b;
	endfunction

	function automatic blend_beat_t flat_blend(input int v, input int n, input bit last);
		blend_beat_t r;
		r.blend_pix_a = (n > 0) ? PIX_W'(v) : '0;
		r.blend_pix_b = (n > 1) ? PIX_W'(v) : '0;
		r.blend_pix_c = (n > 2) ? PIX_W'(v) : '0;
		r.blend_pix_d = (n > 3) ? PIX_W'(v) : '0;
		r.lanes_out = CNT_W'(n);
		r.block_end_out = last;
		return r;
	endfunction

	function automatic pair_beat_t rand_pairs();
		pair_beat_t b;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		b = raw[$bits(pair_beat_t)-1:0];
		b.lanes_valid = ($urandom_range(99) < 90) ? CNT_W'($urandom_range(1, 4)) :
			CNT_W'($urandom_range(7));
		return b;
	endfunction

	task automatic add_row(input int w0, input int w1, input int den, input pair_beat_t b,
			input bit has_exp, input blend_beat_t e);
		dir_row_t r;
		r.w0 = w0; r.w1 = w1; r.den = den; r.beat = b; r.has_exp = has_exp; r.exp = e;
		dir_rows.push_back(r);
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cyc_cnt);
		err_cnt++;
	endtask

	task automatic wait_drained();
		while (blend_exp_q.size() != 0) @(posedge clk);
		repeat (LAT_CYC + 3) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DEN_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_W0:  wt_past = val[W_W-1:0];
			REG_W1:  wt_future = val[W_W-1:0];
			REG_DEN: blend_den = val;
			default: ;
		endcase
	endtask

	task automatic set_weights(input int w0, input int w1, input int den);
		logic [W_W-1:0] a;
		logic [W_W-1:0] b;
		a = W_W'(w0);
		b = W_W'(w1);
		reg_write(REG_W0, {1'($urandom_range(1)), a});
		reg_write(REG_W1, {1'($urandom_range(1)), b});
		reg_write(REG_DEN, DEN_W'(den));
		reg_write(REG_NONE, DEN_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pairs(input pair_beat_t b, input bit has_exp, input blend_beat_t e);
		pairs.valid <= 1'b1;
		pairs.data  <= b;
		@(posedge clk);
		while (!pairs.ready) @(posedge clk);
		blend_exp_q.push_back(has_exp ? e : blend_predict(b));
		if ($urandom_range(99) < gap_pct) begin
			pairs.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
	endtask

	always @(posedge clk) begin
		blend.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		blend_beat_t w;
		if (arst_n && blend.valid && blend.ready) begin
			if (blend_exp_q.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				w = blend_exp_q.pop_front();
				if (blend.data.blend_pix_a !== w.blend_pix_a)
					report_mismatch("blend_pix_a", blend.data.blend_pix_a, w.blend_pix_a);
				if (blend.data.blend_pix_b !== w.blend_pix_b)
					report_mismatch("blend_pix_b", blend.data.blend_pix_b, w.blend_pix_b);
				if (blend.data.blend_pix_c !== w.blend_pix_c)
					report_mismatch("blend_pix_c", blend.data.blend_pix_c, w.blend_pix_c);
				if (blend.data.blend_pix_d !== w.blend_pix_d)
					report_mismatch("blend_pix_d", blend.data.blend_pix_d, w.blend_pix_d);
				if (blend.data.lanes_out !== w.lanes_out)
					report_mismatch("lanes_out", blend.data.lanes_out, w.lanes_out);
				if (blend.data.block_end_out !== w.block_end_out)
					report_mismatch("block_end_out", blend.data.block_end_out,
						w.block_end_out);
			end
		end
	end

	initial begin
		blend_beat_t none;
		int seg_w0[SEG_CNT];
		int seg_w1[SEG_CNT];
		int seg_den[SEG_CNT];
		none = '0;
		err_cnt = 0;
		cyc_cnt = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		pairs.valid = 1'b0;
		pairs.data = '0;
		blend.ready = 1'b0;
		wt_past = 8'sd1;
		wt_future = 8'sd1;
		blend_den = 9'd2;

		// reset weights give a rounded average
		add_row(1, 1, 2, flat_pairs(0, 0, 4, 0), 1, flat_blend(0, 4, 0));
		add_row(1, 1, 2, flat_pairs(255, 255, 4, 1), 1, flat_blend(255, 4, 1));
		add_row(1, 1, 2, flat_pairs(0, 255, 4, 0), 1, flat_blend(128, 4, 0));
		add_row(1, 1, 2, flat_pairs(200, 100, 2, 1), 1, flat_blend(150, 2, 1));
		add_row(1, 1, 2, flat_pairs(77, 9, 0, 0), 1, flat_blend(0, 0, 0));
		add_row(1, 1, 2, flat_pairs(170, 85, 1, 0), 0, none);
		add_row(1, 1, 2, flat_pairs(85, 170, 3, 1), 0, none);
		add_row(1, 1, 2, rand_pairs(), 0, none);
		add_row(1, 1, 2, flat_pairs(31, 224, 7, 0), 0, none);
		add_row(1, 1, 2, flat_pairs(12, 34, 5, 1), 0, none);
		// negative sums clamp low, big sums clamp high
		add_row(-128, -128, 1, flat_pairs(255, 255, 4, 0), 1, flat_blend(0, 4, 0));
		add_row(-128, -128, 1, flat_pairs(1, 0, 4, 1), 1, flat_blend(0, 4, 1));
		add_row(127, 127, 1, flat_pairs(255, 255, 4, 0), 1, flat_blend(255, 4, 0));
		add_row(0, 0, 2, flat_pairs(255, 255, 4, 0), 1, flat_blend(0, 4, 0));
		// zero denominator acts as one
		add_row(1, 1, 0, flat_pairs(100, 50, 4, 0), 1, flat_blend(150, 4, 0));
		add_row(1, 1, 0, flat_pairs(200, 100, 4, 1), 1, flat_blend(255, 4, 1));
		add_row(127, 127, 256, flat_pairs(255, 255, 4, 0), 0, none);
		add_row(127, 127, 256, flat_pairs(3, 250, 4, 0), 0, none);
		add_row(127, -128, 511, flat_pairs(255, 0, 4, 1), 0, none);
		add_row(-128, 127, 511, flat_pairs(0, 255, 4, 0), 0, none);
		add_row(-1, 1, 300, flat_pairs(10, 255, 4, 0), 0, none);
		add_row(-3, 5, 3, rand_pairs(), 0, none);

		seg_w0  = '{1, 127, -128, 127, -128, 0, 64, -7, 0, 0, 0, 0};
		seg_w1  = '{1, 127, -128, -128, 127, 0, 64, 9, 0, 0, 0, 0};
		seg_den = '{2, 256, 1, 1, 511, 0, 128, 3, 0, 0, 0, 0};
		for (int s = 8; s < SEG_CNT; s++) begin
			seg_w0[s]  = $signed(8'($urandom));
			seg_w1[s]  = $signed(8'($urandom));
			seg_den[s] = $urandom_range(1, 256);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].w0 != int'(wt_past) || dir_rows[i].w1 != int'(wt_future) ||
					dir_rows[i].den != int'(blend_den)) begin
				pairs.valid <= 1'b0;
				wait_drained();
				set_weights(dir_rows[i].w0, dir_rows[i].w1, dir_rows[i].den);
			end
			send_pairs(dir_rows[i].beat, dir_rows[i].has_exp, dir_rows[i].exp);
		end

		for (int s = 0; s < SEG_CNT; s++) begin
			pairs.valid <= 1'b0;
			wait_drained();
			set_weights(seg_w0[s], seg_w1[s], seg_den[s]);
			case (s % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 45; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 45; end
				default: begin gap_pct = 29; stall_pct = 29; end
			endcase
			for (int k = 0; k < SEG_ITEMS; k++)
				send_pairs(rand_pairs(), 0, none);
		end

		pairs.valid <= 1'b0;
		wait_drained();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
